[rtl/core/sha256_message_digest_assert.svh]
// ---------------------------------------------------------------------------
// SHA-256 message digest: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sha256_pkg.sv]
// ---------------------------------------------------------------------------
// SHA-256 package
// Beat types, hash and block types, round constants and initial hash.
// ---------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } dig_t;

  typedef logic [0:7][31:0]  hash_t;
  typedef logic [0:15][31:0] block_t;

  typedef struct packed {
    logic start;  // load block and chain value, run 64 rounds
    logic init;   // reload initial hash value
  } core_ctrl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam hash_t START_HASH = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

[rtl/core/sha256_core.sv]
// ---------------------------------------------------------------------------
// SHA-256 compression core
// One round per cycle over a 16-word schedule window, then chain add.
// ---------------------------------------------------------------------------
module sha256_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::core_ctrl_t ctrl,
  input  sha256_pkg::block_t     blk,
  output sha256_pkg::hash_t      hash,
  output logic                   done
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  sha256_pkg::hash_t  v;
  sha256_pkg::block_t w;
  logic [5:0]         rnd;
  logic               busy;
  logic               fin;

  logic [31:0] t1, t2, big1, big0, pick, vote, sm0, sm1, w_new;

  always_comb begin
    big1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    pick  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    big0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    vote  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + big1 + pick + sha256_pkg::ROUND_K[rnd] + w[0];
    t2    = big0 + vote;
    sm0   = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    sm1   = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + sm0 + w[9] + sm1;
  end

  // control and chain value
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      rnd  <= '0;
      hash <= sha256_pkg::START_HASH;
    end else begin
      done <= 1'b0;
      if (ctrl.init) begin
        hash <= sha256_pkg::START_HASH;
      end
      if (ctrl.start) begin
        busy <= 1'b1;
        rnd  <= '0;
      end else if (busy) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + v[i];
        end
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      v <= hash;
      w <= blk;
    end else if (busy) begin
      v <= '{t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};
      w <= {w[1:15], w_new};
    end
  end

endmodule

[rtl/core/sha256_message_digest.sv]
// ---------------------------------------------------------------------------
// SHA-256 message digest
// Byte-wide message in, eight 32-bit digest words out per message.
// ---------------------------------------------------------------------------
// Input: a data beat is taken while idle; every 64th byte stalls the input
//   through core load, 64 rounds in the shared round unit, chain add, handoff.
// Last beat: padding sweep to the end of each final block, one or two
//   final blocks, then 8 digest beats, one per cycle when not stalled.
// Input is stalled outside idle: no new byte is taken while a block hashes.
// Reset: sync active-high rst loads the initial hash and clears the count.
// ---------------------------------------------------------------------------
`include "sha256_message_digest_assert.svh"

module sha256_message_digest (
  input  logic              clk,
  input  logic              rst,
  // message beats
  input  logic              msg_valid,
  output logic              msg_stall,
  input  sha256_pkg::msg_t  msg,
  // digest beats
  output logic              dig_valid,
  input  logic              dig_stall,
  output sha256_pkg::dig_t  dig
);

  localparam logic [1:0] S_IDLE = 2'd0;  // taking message beats
  localparam logic [1:0] S_PAD  = 2'd1;  // writing pad / zero / length bytes
  localparam logic [1:0] S_HASH = 2'd2;  // core running a block
  localparam logic [1:0] S_OUT  = 2'd3;  // sending digest words

  logic [1:0]  state;
  logic [60:0] cnt;         // message bytes, wraps mod 2^61
  logic [5:0]  pad_pos;     // sweep position inside the block
  logic        pad_first;   // next pad write is the 0x80 marker
  logic        len_blk;     // block being padded/hashed carries the bit length
  logic        in_pad;      // padding has begun
  logic        pad_pend;    // last beat arrived with a full block
  logic        start;
  logic [2:0]  oidx;

  // block buffer, big-endian words, byte writes only
  sha256_pkg::block_t blk;

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_data;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [7:0]  pad_data;
  logic [5:0]  pos;
  logic [5:0]  pos_after;
  logic        msg_take;
  logic        dig_take;
  logic        core_done;

  sha256_pkg::hash_t      hash;
  sha256_pkg::core_ctrl_t core_ctrl;

  assign pos       = cnt[5:0];
  assign pos_after = pos + 6'd1;
  assign msg_take  = msg_valid && !msg_stall;
  assign dig_take  = dig_valid && !dig_stall;
  assign msg_stall = (state != S_IDLE);

  assign bit_len  = {cnt, 3'b000};
  assign len_byte = bit_len[{~pad_pos[2:0], 3'b000} +: 8];
  // length goes in bytes 56..63 of the length block only
  assign pad_data = pad_first ? sha256_pkg::PAD_BYTE :
                    (len_blk && pad_pos[5:3] == 3'b111) ? len_byte : 8'h00;

  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = pos;
    wr_data = msg.data_byte;
    if (state == S_IDLE) begin
      wr_en = msg_take && msg.has_byte;
    end else if (state == S_PAD) begin
      wr_en   = 1'b1;
      wr_pos  = pad_pos;
      wr_data = pad_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_data;
    end
  end

  assign core_ctrl.start = start;
  assign core_ctrl.init  = dig_take && (oidx == 3'd7);

  sha256_core u_core (
    .clk  (clk),
    .rst  (rst),
    .ctrl (core_ctrl),
    .blk  (blk),
    .hash (hash),
    .done (core_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pad_pos   <= '0;
      pad_first <= 1'b0;
      len_blk   <= 1'b0;
      in_pad    <= 1'b0;
      pad_pend  <= 1'b0;
      start     <= 1'b0;
      oidx      <= '0;
    end else begin
      start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (msg_take) begin
            if (msg.has_byte) begin
              cnt <= cnt + 61'd1;
              if (pos == 6'd63) begin
                // full block: hash it, pad afterwards if this was last
                pad_pend <= msg.last;
                start    <= 1'b1;
                state    <= S_HASH;
              end else if (msg.last) begin
                pad_pos   <= pos_after;
                pad_first <= 1'b1;
                len_blk   <= (pos_after[5:3] != 3'b111);
                in_pad    <= 1'b1;
                state     <= S_PAD;
              end
            end else if (msg.last) begin
              pad_pos   <= pos;
              pad_first <= 1'b1;
              len_blk   <= (pos[5:3] != 3'b111);
              in_pad    <= 1'b1;
              state     <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          pad_pos   <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) begin
            start <= 1'b1;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (core_done) begin
            if (len_blk) begin
              oidx  <= '0;
              state <= S_OUT;
            end else if (pad_pend) begin
              // count sits on a block boundary here
              pad_pend  <= 1'b0;
              pad_pos   <= pos;
              pad_first <= 1'b1;
              len_blk   <= 1'b1;
              in_pad    <= 1'b1;
              state     <= S_PAD;
            end else if (in_pad) begin
              // marker went in the previous block; zeros then length
              pad_pos   <= '0;
              pad_first <= 1'b0;
              len_blk   <= 1'b1;
              state     <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (dig_take) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              cnt     <= '0;
              len_blk <= 1'b0;
              in_pad  <= 1'b0;
              state   <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign dig_valid       = (state == S_OUT);
  assign dig.digest_word = hash[oidx];
  assign dig.word_index  = oidx;
  assign dig.final_word  = (oidx == 3'd7);

  // checks
  `SHA_ASSERT_NOW(a_done_in_hash, core_done, state == S_HASH,
    "core finished outside the hash state")
  `SHA_ASSERT_NOW(a_marker_before_len, (state == S_PAD) && pad_first && len_blk,
    pad_pos[5:3] != 3'b111, "pad marker would overlap the length field")
  `SHA_ASSERT_NEXT(a_clear_after_digest, dig_take && dig.final_word,
    (cnt == 61'd0) && (state == S_IDLE), "byte count not cleared after digest")

endmodule
